>>> rtl/kreyv_pkg.sv
// ----------------------------------------------------------------------------
// Kreyvium decrypt package
// Sizes, tap positions, codes and shared types of the Kreyvium byte decryptor.
// ----------------------------------------------------------------------------
package kreyv_pkg;

	// Register sizes.
	localparam int MAIN_REG_BITS = 288;
	localparam int ROTOR_SIZE = 128;
	localparam int KEY_LOAD_BITS = 93;
	localparam int BYTE_BITS = 8;
	localparam int CFG_WIDTH = 64;
	localparam int CFG_INDEX_WIDTH = 2;

	// Default number of warm-up clocks after an init request.
	localparam int WARMUP_CLOCKS_DEF = 1152;

	// Tap positions of the main register.
	localparam int TAP_A1 = 65;
	localparam int TAP_A2 = 92;
	localparam int TAP_B1 = 161;
	localparam int TAP_B2 = 176;
	localparam int TAP_C1 = 242;
	localparam int TAP_C2 = 287;
	localparam int TAP_A_FB = 170;
	localparam int TAP_B_FB = 263;
	localparam int TAP_C_FB = 68;
	localparam int AND_A = 90;
	localparam int AND_B = 174;
	localparam int AND_C = 285;
	localparam int INS_A = 93;
	localparam int INS_B = 177;

	// Request modes.
	localparam logic MODE_INIT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KEY_LOW = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IV_HIGH = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IV_LOW = 2'd3;

	// Commands from the sequencer to the cipher core.
	typedef struct packed {
		logic load;
		logic step;
	} core_ctrl_t;

endpackage

>>> rtl/kreyv_if.sv
// ----------------------------------------------------------------------------
// Kreyvium decrypt channels
// Valid/ready channels for decrypt requests and decrypted bytes.
// ----------------------------------------------------------------------------

// Request channel: mode and one ciphertext byte.
interface kreyv_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] cipher_byte;

	modport source (output valid, output mode, output cipher_byte, input ready);
	modport sink (input valid, input mode, input cipher_byte, output ready);
endinterface

// Result channel: one decrypted byte.
interface kreyv_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;

	modport source (output valid, output plain_byte, input ready);
	modport sink (input valid, input plain_byte, output ready);
endinterface

>>> rtl/kreyv_core.sv
// ----------------------------------------------------------------------------
// Kreyvium cipher core
// The 288-bit main register and the two 128-bit rotors, one cipher clock
// per step command, one keystream bit out per step.
// ----------------------------------------------------------------------------
module kreyv_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kreyv_pkg::core_ctrl_t            ctrl,
	input  logic [kreyv_pkg::ROTOR_SIZE-1:0] key,
	input  logic [kreyv_pkg::ROTOR_SIZE-1:0] iv,
	output logic                             z
);

	logic [kreyv_pkg::MAIN_REG_BITS-1:0] s_q;
	logic [kreyv_pkg::ROTOR_SIZE-1:0]    key_rotor_q;
	logic [kreyv_pkg::ROTOR_SIZE-1:0]    iv_rotor_q;
	logic [kreyv_pkg::MAIN_REG_BITS-1:0] s_load;
	logic [kreyv_pkg::MAIN_REG_BITS-1:0] s_next;
	logic                                t1;
	logic                                t2;
	logic                                t3;
	logic                                f1;
	logic                                f2;
	logic                                f3;

	// Initial main register: key bits, IV bits, ones and a final zero.
	// Key and IV bit i sits at vector position ROTOR_SIZE-1-i.
	always_comb begin
		s_load = '1;
		for (int i = 0; i < kreyv_pkg::KEY_LOAD_BITS; i++) begin
			s_load[i] = key[kreyv_pkg::ROTOR_SIZE-1-i];
		end
		for (int i = 0; i < kreyv_pkg::ROTOR_SIZE; i++) begin
			s_load[kreyv_pkg::KEY_LOAD_BITS+i] = iv[kreyv_pkg::ROTOR_SIZE-1-i];
		end
		s_load[kreyv_pkg::MAIN_REG_BITS-1] = 1'b0;
	end

	// Keystream bit and feedback of one cipher clock.
	always_comb begin
		t1 = s_q[kreyv_pkg::TAP_A1] ^ s_q[kreyv_pkg::TAP_A2];
		t2 = s_q[kreyv_pkg::TAP_B1] ^ s_q[kreyv_pkg::TAP_B2];
		t3 = s_q[kreyv_pkg::TAP_C1] ^ s_q[kreyv_pkg::TAP_C2]
			^ key_rotor_q[kreyv_pkg::ROTOR_SIZE-1];
		z = t1 ^ t2 ^ t3;
		f1 = t1 ^ s_q[kreyv_pkg::TAP_A_FB] ^ iv_rotor_q[kreyv_pkg::ROTOR_SIZE-1]
			^ (s_q[kreyv_pkg::AND_A] & s_q[kreyv_pkg::AND_A+1]);
		f2 = t2 ^ s_q[kreyv_pkg::TAP_B_FB]
			^ (s_q[kreyv_pkg::AND_B] & s_q[kreyv_pkg::AND_B+1]);
		f3 = t3 ^ s_q[kreyv_pkg::TAP_C_FB]
			^ (s_q[kreyv_pkg::AND_C] & s_q[kreyv_pkg::AND_C+1]);
		s_next = {s_q[kreyv_pkg::MAIN_REG_BITS-2:0], f3};
		s_next[kreyv_pkg::INS_A] = f1;
		s_next[kreyv_pkg::INS_B] = f2;
	end

	// State registers: parallel load on init, one shift per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
			key_rotor_q <= '0;
			iv_rotor_q <= '0;
		end else if (ctrl.load) begin
			s_q <= s_load;
			key_rotor_q <= key;
			iv_rotor_q <= iv;
		end else if (ctrl.step) begin
			s_q <= s_next;
			key_rotor_q <= {key_rotor_q[kreyv_pkg::ROTOR_SIZE-2:0],
				key_rotor_q[kreyv_pkg::ROTOR_SIZE-1]};
			iv_rotor_q <= {iv_rotor_q[kreyv_pkg::ROTOR_SIZE-2:0],
				iv_rotor_q[kreyv_pkg::ROTOR_SIZE-1]};
		end
	end

endmodule

>>> rtl/kreyv_seq.sv
// ----------------------------------------------------------------------------
// Kreyvium request sequencer
// Accepts requests, counts warm-up and byte clocks, shifts the ciphertext
// byte one bit per clock and holds the result for the receiver.
// ----------------------------------------------------------------------------
module kreyv_seq #(
	parameter int WARMUP_CLOCKS = kreyv_pkg::WARMUP_CLOCKS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	kreyv_in_if.sink               in_ch,
	kreyv_out_if.source            out_ch,
	output kreyv_pkg::core_ctrl_t  ctrl,
	input  logic                   z
);

	localparam int MAX_COUNT = (WARMUP_CLOCKS > kreyv_pkg::BYTE_BITS) ?
		WARMUP_CLOCKS : kreyv_pkg::BYTE_BITS;
	localparam int CNT_W = $clog2(MAX_COUNT + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             mode_q;
	logic [7:0]       byte_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             in_fire;
	logic             slot_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.plain_byte = out_byte_q;

	// Core commands.
	always_comb begin
		ctrl.load = (state_q == ST_LOAD);
		ctrl.step = (state_q == ST_RUN) && (cnt_q != '0);
	end

	// Control state: idle, load on an init, then one cipher clock per count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			mode_q <= kreyv_pkg::MODE_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						mode_q <= in_ch.mode;
						if (in_ch.mode == kreyv_pkg::MODE_INIT) begin
							state_q <= ST_LOAD;
						end else begin
							cnt_q <= CNT_W'(kreyv_pkg::BYTE_BITS);
							state_q <= ST_RUN;
						end
					end
				end
				ST_LOAD: begin
					cnt_q <= CNT_W'(WARMUP_CLOCKS);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Byte path: rotate left, decrypting the top bit as it wraps into bit 0.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q <= in_ch.cipher_byte;
		end else if (ctrl.step && (mode_q == kreyv_pkg::MODE_DECRYPT)) begin
			byte_q <= {byte_q[6:0], byte_q[7] ^ z};
		end
		if ((state_q == ST_RUN) && (cnt_q == '0) && slot_free) begin
			out_byte_q <= (mode_q == kreyv_pkg::MODE_DECRYPT) ? byte_q : 8'h00;
		end
	end

`ifndef SYNTHESIS
	a_no_load_and_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.load && ctrl.step))
		else $error("load and step commanded together");

	a_init_goes_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_ch.mode == kreyv_pkg::MODE_INIT)) |=> (state_q == ST_LOAD))
		else $error("init request did not load the core");

	a_result_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RUN) && ($past(cnt_q) == '0))
		else $error("result raised before all clocks ran");

	a_load_starts_warmup: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> (cnt_q == CNT_W'(WARMUP_CLOCKS)) && (state_q == ST_RUN))
		else $error("warm-up count not started after load");
`endif

endmodule

>>> rtl/kreyvium_stream_decrypt_unit.sv
// ----------------------------------------------------------------------------
// Kreyvium stream decrypt unit
// Top level: configuration registers, request sequencer and cipher core.
// ----------------------------------------------------------------------------
// Usage:
// Key and IV are written through the plain write port (cfg_we, cfg_index,
// cfg_data) while the unit is idle; they are sampled only by an init request.
// Requests arrive on in_ch. Mode init loads the main register and rotors
// and runs the WARMUP_CLOCKS warm-up steps; its result is a zero byte.
// Mode decrypt runs eight cipher steps, one keystream bit per step, and
// XORs them MSB first into cipher_byte.
// One request is worked at a time: in_ch is ready only while the sequencer
// is idle, so the next request is taken only once the last one has passed
// its result to the output register.
// The result is held in an output register until out_ch takes it; while it
// waits the next request is accepted and run, and only its final write
// waits for the register to empty.
// Reset clears the cipher state, rotors and key/IV registers to zero and
// drops all valid flags.
// ----------------------------------------------------------------------------
module kreyvium_stream_decrypt_unit #(
	parameter int WARMUP_CLOCKS = kreyv_pkg::WARMUP_CLOCKS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [kreyv_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [kreyv_pkg::CFG_WIDTH-1:0]       cfg_data,
	kreyv_in_if.sink                              in_ch,
	kreyv_out_if.source                           out_ch
);

	logic [kreyv_pkg::CFG_WIDTH-1:0] key_high_q;
	logic [kreyv_pkg::CFG_WIDTH-1:0] key_low_q;
	logic [kreyv_pkg::CFG_WIDTH-1:0] iv_high_q;
	logic [kreyv_pkg::CFG_WIDTH-1:0] iv_low_q;
	kreyv_pkg::core_ctrl_t           ctrl;
	logic                            z;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				kreyv_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				kreyv_pkg::CFG_KEY_LOW: key_low_q <= cfg_data;
				kreyv_pkg::CFG_IV_HIGH: iv_high_q <= cfg_data;
				kreyv_pkg::CFG_IV_LOW: iv_low_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request sequencer.
	kreyv_seq #(
		.WARMUP_CLOCKS(WARMUP_CLOCKS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.ctrl   (ctrl),
		.z      (z)
	);

	// Cipher core.
	kreyv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.key    ({key_high_q, key_low_q}),
		.iv     ({iv_high_q, iv_low_q}),
		.z      (z)
	);

endmodule

>>> test/kreyvium_stream_decrypt_unit_tb.sv
// ----------------------------------------------------------------------------
// Kreyvium stream decrypt unit testbench
// Drives init and decrypt requests through the request channel and writes
// key/IV settings between phases. A scoreboard object keeps its own copy of
// the cipher state and predicts every decrypted byte. Results are checked in
// order, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module kreyvium_stream_decrypt_unit_tb;

	localparam int RANDOM_ITEMS = 880;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 4 * (kreyv_pkg::WARMUP_CLOCKS_DEF + 3 + LONG_HOLD);
	localparam int DRAIN_CYCLES = 2 * (kreyv_pkg::WARMUP_CLOCKS_DEF + 3);

	typedef struct packed {
		logic       mode;
		logic [7:0] cipher_byte;
	} request_t;

	// Scoreboard: predicts the plain byte of each accepted request and checks results.
	class decrypt_board;
		bit [kreyv_pkg::MAIN_REG_BITS-1:0] cipher_state;
		bit [kreyv_pkg::ROTOR_SIZE-1:0]    key_rot;
		bit [kreyv_pkg::ROTOR_SIZE-1:0]    iv_rot;
		bit [kreyv_pkg::CFG_WIDTH-1:0]     key_hi;
		bit [kreyv_pkg::CFG_WIDTH-1:0]     key_lo;
		bit [kreyv_pkg::CFG_WIDTH-1:0]     iv_hi;
		bit [kreyv_pkg::CFG_WIDTH-1:0]     iv_lo;
		logic [7:0]                        plain_q[$];
		int                                fail_count;

		function new();
			cipher_state = '0;
			key_rot = '0;
			iv_rot = '0;
			key_hi = '0;
			key_lo = '0;
			iv_hi = '0;
			iv_lo = '0;
			fail_count = 0;
		endfunction

		function void write_cfg(logic [kreyv_pkg::CFG_INDEX_WIDTH-1:0] index,
			logic [kreyv_pkg::CFG_WIDTH-1:0] data);
			case (index)
				kreyv_pkg::CFG_KEY_HIGH: key_hi = data;
				kreyv_pkg::CFG_KEY_LOW: key_lo = data;
				kreyv_pkg::CFG_IV_HIGH: iv_hi = data;
				kreyv_pkg::CFG_IV_LOW: iv_lo = data;
				default: ;
			endcase
		endfunction

		// Bit i of the 128-bit key or IV; bit 0 sits in the MSB of the high word.
		function bit key_bit(int i);
			if (i < 64)
				return key_hi[63 - i];
			return key_lo[127 - i];
		endfunction

		function bit iv_bit(int i);
			if (i < 64)
				return iv_hi[63 - i];
			return iv_lo[127 - i];
		endfunction

		// One cipher clock; returns the keystream bit.
		function bit cipher_clock();
			bit kb;
			bit ib;
			bit t1;
			bit t2;
			bit t3;
			bit z;
			kb = key_rot[kreyv_pkg::ROTOR_SIZE-1];
			ib = iv_rot[kreyv_pkg::ROTOR_SIZE-1];
			t1 = cipher_state[kreyv_pkg::TAP_A1] ^ cipher_state[kreyv_pkg::TAP_A2];
			t2 = cipher_state[kreyv_pkg::TAP_B1] ^ cipher_state[kreyv_pkg::TAP_B2];
			t3 = cipher_state[kreyv_pkg::TAP_C1] ^ cipher_state[kreyv_pkg::TAP_C2] ^ kb;
			z = t1 ^ t2 ^ t3;
			t1 = t1 ^ cipher_state[kreyv_pkg::TAP_A_FB] ^ ib
				^ (cipher_state[kreyv_pkg::AND_A] & cipher_state[kreyv_pkg::AND_A+1]);
			t2 = t2 ^ cipher_state[kreyv_pkg::TAP_B_FB]
				^ (cipher_state[kreyv_pkg::AND_B] & cipher_state[kreyv_pkg::AND_B+1]);
			t3 = t3 ^ cipher_state[kreyv_pkg::TAP_C_FB]
				^ (cipher_state[kreyv_pkg::AND_C] & cipher_state[kreyv_pkg::AND_C+1]);
			cipher_state = {cipher_state[kreyv_pkg::MAIN_REG_BITS-2:0], t3};
			cipher_state[kreyv_pkg::INS_A] = t1;
			cipher_state[kreyv_pkg::INS_B] = t2;
			key_rot = {key_rot[kreyv_pkg::ROTOR_SIZE-2:0], kb};
			iv_rot = {iv_rot[kreyv_pkg::ROTOR_SIZE-2:0], ib};
			return z;
		endfunction

		// Load state and rotors from the key/IV copies, then warm up.
		function void load_state();
			int i;
			for (i = 0; i < kreyv_pkg::KEY_LOAD_BITS; i++)
				cipher_state[i] = key_bit(i);
			for (i = 0; i < kreyv_pkg::ROTOR_SIZE; i++) begin
				cipher_state[kreyv_pkg::INS_A + i] = iv_bit(i);
				iv_rot[i] = iv_bit(kreyv_pkg::ROTOR_SIZE - 1 - i);
				key_rot[i] = key_bit(kreyv_pkg::ROTOR_SIZE - 1 - i);
			end
			for (i = kreyv_pkg::INS_A + kreyv_pkg::ROTOR_SIZE;
				i < kreyv_pkg::MAIN_REG_BITS - 1; i++)
				cipher_state[i] = 1'b1;
			cipher_state[kreyv_pkg::MAIN_REG_BITS-1] = 1'b0;
			for (i = 0; i < kreyv_pkg::WARMUP_CLOCKS_DEF; i++)
				void'(cipher_clock());
		endfunction

		function void note_request(logic mode, logic [7:0] cb);
			logic [7:0] pb;
			int k;
			pb = '0;
			if (mode == kreyv_pkg::MODE_INIT) begin
				load_state();
			end else begin
				for (k = 0; k < kreyv_pkg::BYTE_BITS; k++)
					pb[7 - k] = cipher_clock() ^ cb[7 - k];
			end
			plain_q = {plain_q, pb};
		endfunction

		function int pending();
			return plain_q.size();
		endfunction

		task report(string msg);
			$display("tb: error: %s", msg);
			fail_count++;
		endtask

		task check_result(logic [7:0] got);
			logic [7:0] want;
			if (plain_q.size() == 0) begin
				report($sformatf("plain byte %02h arrived with no request waiting", got));
				return;
			end
			want = plain_q.pop_front();
			if (got !== want)
				report($sformatf("plain byte %02h, predicted %02h", got, want));
		endtask

		task check_drained();
			if (plain_q.size() > 0)
				report($sformatf("%0d plain bytes never arrived", plain_q.size()));
		endtask
	endclass

	logic                                  clk;
	logic                                  arst_n;
	logic                                  cfg_we;
	logic [kreyv_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [kreyv_pkg::CFG_WIDTH-1:0]       cfg_data;

	kreyv_in_if  in_ch();
	kreyv_out_if out_ch();

	decrypt_board board;
	request_t     plan_q[$];
	bit           sender_calm;
	bit           long_hold_req;
	int           sent_count;
	int           idle_cycles;

	kreyvium_stream_decrypt_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: ends the run when no request or result moves for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Write one register; the caller drops cfg_we after the last write.
	task write_register(logic [kreyv_pkg::CFG_INDEX_WIDTH-1:0] index,
		logic [kreyv_pkg::CFG_WIDTH-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		board.write_cfg(index, data);
	endtask

	function logic [kreyv_pkg::CFG_WIDTH-1:0] pick_cfg_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random key/IV setting: each register is rewritten with even odds.
	task write_random_setting();
		int i;
		for (i = 0; i < 4; i++) begin
			if ($urandom_range(0, 1))
				write_register(kreyv_pkg::CFG_INDEX_WIDTH'(i), pick_cfg_value());
		end
		cfg_we <= 1'b0;
	endtask

	function void plan(logic mode, logic [7:0] cb);
		request_t req;
		req.mode = mode;
		req.cipher_byte = cb;
		plan_q = {plan_q, req};
	endfunction

	// Send every planned request; at request hold_at the receiver is told to hold off.
	task drive_requests(int hold_at);
		request_t req;
		int gap;
		int n;
		n = 0;
		while (plan_q.size() > 0) begin
			req = plan_q.pop_front();
			gap = sender_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.mode <= req.mode;
			in_ch.cipher_byte <= req.cipher_byte;
			if (n == hold_at)
				long_hold_req = 1'b1;
			do @(posedge clk); while (!in_ch.ready);
			board.note_request(req.mode, req.cipher_byte);
			sent_count++;
			n++;
		end
		in_ch.valid <= 1'b0;
	endtask

	task wait_drained();
		while (board.pending() > 0) @(posedge clk);
	endtask

	// Result side: random stalls, calm stretches and one long hold-off.
	initial begin
		int gap;
		int calm_left;
		calm_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				gap = LONG_HOLD;
			end else if (calm_left > 0) begin
				calm_left--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 8);
				if ($urandom_range(0, 15) == 0)
					calm_left = $urandom_range(10, 40);
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			board.check_result(out_ch.plain_byte);
		end
	end

	// Main sequence: reset, directed phases, random phases, drain and verdict.
	initial begin
		int phase;
		int n;
		int i;
		int first_random;
		board = new();
		sent_count = 0;
		idle_cycles = 0;
		long_hold_req = 1'b0;
		sender_calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= kreyv_pkg::CFG_KEY_HIGH;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= kreyv_pkg::MODE_INIT;
		in_ch.cipher_byte <= '0;
		out_ch.ready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decrypt before any init runs on the all-zero state.
		plan(kreyv_pkg::MODE_DECRYPT, 8'h00);
		plan(kreyv_pkg::MODE_DECRYPT, 8'hFF);
		plan(kreyv_pkg::MODE_DECRYPT, 8'hA5);
		drive_requests(-1);
		wait_drained();

		// All-zero key and IV.
		write_register(kreyv_pkg::CFG_KEY_HIGH, '0);
		write_register(kreyv_pkg::CFG_KEY_LOW, '0);
		write_register(kreyv_pkg::CFG_IV_HIGH, '0);
		write_register(kreyv_pkg::CFG_IV_LOW, '0);
		cfg_we <= 1'b0;
		plan(kreyv_pkg::MODE_INIT, 8'h00);
		plan(kreyv_pkg::MODE_DECRYPT, 8'h00);
		plan(kreyv_pkg::MODE_DECRYPT, 8'hFF);
		drive_requests(-1);
		wait_drained();

		// All-ones key and IV; the init byte carries data that must be ignored.
		sender_calm = 1'b1;
		write_register(kreyv_pkg::CFG_KEY_HIGH, '1);
		write_register(kreyv_pkg::CFG_KEY_LOW, '1);
		write_register(kreyv_pkg::CFG_IV_HIGH, '1);
		write_register(kreyv_pkg::CFG_IV_LOW, '1);
		cfg_we <= 1'b0;
		plan(kreyv_pkg::MODE_INIT, 8'hFF);
		plan(kreyv_pkg::MODE_DECRYPT, 8'h00);
		plan(kreyv_pkg::MODE_DECRYPT, 8'hFF);
		plan(kreyv_pkg::MODE_DECRYPT, 8'h80);
		plan(kreyv_pkg::MODE_DECRYPT, 8'h01);
		plan(kreyv_pkg::MODE_DECRYPT, 8'h5A);
		drive_requests(-1);
		wait_drained();

		// A new setting only counts from the next init; a second init follows two bytes on.
		sender_calm = 1'b0;
		write_register(kreyv_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
		write_register(kreyv_pkg::CFG_KEY_LOW, 64'd1 << $urandom_range(0, 63));
		write_register(kreyv_pkg::CFG_IV_HIGH, {$urandom, $urandom});
		write_register(kreyv_pkg::CFG_IV_LOW, {$urandom, $urandom});
		cfg_we <= 1'b0;
		plan(kreyv_pkg::MODE_DECRYPT, 8'h3C);
		plan(kreyv_pkg::MODE_DECRYPT, 8'hC3);
		plan(kreyv_pkg::MODE_INIT, 8'h00);
		plan(kreyv_pkg::MODE_DECRYPT, 8'h00);
		plan(kreyv_pkg::MODE_DECRYPT, 8'hFF);
		plan(kreyv_pkg::MODE_INIT, 8'hFF);
		plan(kreyv_pkg::MODE_DECRYPT, 8'h7E);
		drive_requests(-1);
		wait_drained();

		// Random phases: mostly a fresh init followed by a run of bytes.
		phase = 0;
		first_random = sent_count;
		while (sent_count - first_random < RANDOM_ITEMS) begin
			write_random_setting();
			sender_calm = ($urandom_range(0, 3) == 0);
			if (phase == 2)
				n = 120;
			else if ($urandom_range(0, 7) == 0)
				n = $urandom_range(100, 200);
			else
				n = $urandom_range(10, 50);
			if ($urandom_range(0, 9) != 0)
				plan(kreyv_pkg::MODE_INIT, 8'($urandom_range(0, 255)));
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 29) == 0)
					plan(kreyv_pkg::MODE_INIT, 8'($urandom_range(0, 255)));
				else
					plan(kreyv_pkg::MODE_DECRYPT, 8'($urandom_range(0, 255)));
			end
			drive_requests(phase == 2 ? 5 : -1);
			wait_drained();
			phase++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		board.check_drained();
		if (board.fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
